>>> rtl/assert_macros.svh
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ssr_pkg.sv
// shared types and constants of the score sort and rank block
`default_nettype none

package ssr_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int ID_W        = 20;
    localparam int SCORE_W     = 16;
    localparam int RANK_W      = 7;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int POS_W       = $clog2(MAX_RECORDS);

    typedef logic [ID_W-1:0]    id_t;
    typedef logic [SCORE_W-1:0] score_t;
    typedef logic [RANK_W-1:0]  rank_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [POS_W-1:0]   pos_t;

    typedef struct packed {
        id_t    student_id;
        score_t score;
        logic   last_record;
    } in_t;

    typedef struct packed {
        id_t    student_id_res;
        score_t score_res;
        rank_t  rank;
        logic   last_result;
        logic   dropped_any;
    } out_t;

    typedef struct packed {
        id_t    id;
        score_t score;
    } rec_t;

    // chain control: insert the broadcast record, or shift toward the head
    typedef struct packed {
        logic insert;
        logic shift;
    } ctrl_t;

endpackage

`default_nettype wire

>>> rtl/ssr_cell.sv
// one sorting cell: holds a record and trades it with its neighbors
`default_nettype none

module ssr_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ssr_pkg::ctrl_t ctrl,
    input  wire ssr_pkg::rec_t new_rec,
    input  wire logic          prev_keep,
    input  wire ssr_pkg::rec_t prev_rec,
    input  wire logic          prev_valid,
    input  wire ssr_pkg::rec_t next_rec,
    input  wire logic          next_valid,
    output logic               keep,
    output ssr_pkg::rec_t      rec,
    output logic               valid
);

    logic          valid_reg;
    logic          valid_next;
    ssr_pkg::rec_t rec_reg;
    ssr_pkg::rec_t rec_next;

    // stored record stays when its score is at least the new one (ties keep arrival order)
    assign keep  = valid_reg && (rec_reg.score >= new_rec.score);
    assign rec   = rec_reg;
    assign valid = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        if (ctrl.insert)
        begin
            if (!keep)
            begin
                if (prev_keep)
                begin
                    rec_next   = new_rec;
                    valid_next = 1'b1;
                end
                else
                begin
                    rec_next   = prev_rec;
                    valid_next = prev_valid;
                end
            end
        end
        else if (ctrl.shift)
        begin
            rec_next   = next_rec;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

`default_nettype wire

>>> rtl/ssr_chain.sv
// row of sorting cells, highest score at the head
`default_nettype none

module ssr_chain (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ssr_pkg::ctrl_t ctrl,
    input  wire ssr_pkg::rec_t  new_rec,
    output ssr_pkg::rec_t       head_rec,
    output logic                head_valid
);

    localparam int N = ssr_pkg::MAX_RECORDS;

    ssr_pkg::rec_t recs   [N];
    logic          valids [N];
    logic          keeps  [N];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            ssr_pkg::rec_t prev_rec;
            logic          prev_valid;
            logic          prev_keep;
            ssr_pkg::rec_t next_rec;
            logic          next_valid;

            if (i == 0)
            begin : g_head
                // head has nothing above it, so a displaced slot there takes the new record
                assign prev_rec   = new_rec;
                assign prev_valid = 1'b0;
                assign prev_keep  = 1'b1;
            end
            else
            begin : g_body
                assign prev_rec   = recs[i-1];
                assign prev_valid = valids[i-1];
                assign prev_keep  = keeps[i-1];
            end

            if (i == N - 1)
            begin : g_tail
                assign next_rec   = new_rec;
                assign next_valid = 1'b0;
            end
            else
            begin : g_link
                assign next_rec   = recs[i+1];
                assign next_valid = valids[i+1];
            end

            ssr_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_rec    (new_rec),
                .prev_keep  (prev_keep),
                .prev_rec   (prev_rec),
                .prev_valid (prev_valid),
                .next_rec   (next_rec),
                .next_valid (next_valid),
                .keep       (keeps[i]),
                .rec        (recs[i]),
                .valid      (valids[i])
            );
        end
    endgenerate

    assign head_rec   = recs[0];
    assign head_valid = valids[0];

endmodule

`default_nettype wire

>>> rtl/score_sort_rank.sv
// score sort and rank: top level with load control and ranked emission
//
// Records load one per cycle, while busy is low, into a row of sorting cells
// (up to MAX_RECORDS), each placed on arrival behind every stored record with
// an equal or higher score; a record that arrives with the row full is dropped
// and flags the set. A transaction is taken when start is high and busy is
// low. The transaction with last_record set closes the set: busy then stays
// high while the row shifts out one record per cycle toward the head, and the
// stored records follow as results one per cycle, each registered from the
// head and marked by result_valid for a single cycle. The receiver cannot
// stall them.
`default_nettype none

module score_sort_rank (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire ssr_pkg::in_t record,
    output logic              busy,
    output logic              result_valid,
    output ssr_pkg::out_t     result
);

    ssr_pkg::count_t count_reg;
    ssr_pkg::count_t count_next;
    logic            overflow_reg;
    logic            overflow_next;
    logic            emit_reg;
    logic            emit_next;
    ssr_pkg::pos_t   pos_reg;
    ssr_pkg::pos_t   pos_next;
    ssr_pkg::score_t prev_score_reg;
    ssr_pkg::score_t prev_score_next;
    ssr_pkg::rank_t  rank_reg;
    ssr_pkg::rank_t  rank_next;
    logic            result_valid_reg;
    logic            result_valid_next;
    ssr_pkg::out_t   result_reg;
    ssr_pkg::out_t   result_next;

    logic            accept;
    logic            full;
    ssr_pkg::ctrl_t  ctrl;
    ssr_pkg::rec_t   new_rec;
    ssr_pkg::rec_t   head_rec;
    logic            head_valid;
    logic            final_emit;
    ssr_pkg::rank_t  cur_rank;

    assign accept = start && !emit_reg;
    assign full   = (count_reg == ssr_pkg::count_t'(ssr_pkg::MAX_RECORDS));

    assign new_rec.id    = record.student_id;
    assign new_rec.score = record.score;

    assign ctrl.insert = accept && !full;
    assign ctrl.shift  = emit_reg;

    ssr_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_rec    (new_rec),
        .head_rec   (head_rec),
        .head_valid (head_valid)
    );

    assign final_emit = emit_reg && (count_reg == ssr_pkg::count_t'(1));

    // competition rank: a new score takes position plus one, a tie keeps the rank above
    assign cur_rank = ((pos_reg == '0) || (head_rec.score != prev_score_reg))
                    ? ssr_pkg::rank_t'(pos_reg) + ssr_pkg::rank_t'(1)
                    : rank_reg;

    always_comb
    begin
        count_next        = count_reg;
        overflow_next     = overflow_reg;
        emit_next         = emit_reg;
        pos_next          = pos_reg;
        prev_score_next   = prev_score_reg;
        rank_next         = rank_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        if (emit_reg)
        begin
            result_valid_next          = head_valid;
            result_next.student_id_res = head_rec.id;
            result_next.score_res      = head_rec.score;
            result_next.rank           = cur_rank;
            result_next.last_result    = final_emit;
            result_next.dropped_any    = overflow_reg;
            prev_score_next            = head_rec.score;
            rank_next                  = cur_rank;
            count_next                 = count_reg - ssr_pkg::count_t'(1);
            pos_next                   = pos_reg + ssr_pkg::pos_t'(1);
            if (final_emit)
            begin
                emit_next     = 1'b0;
                overflow_next = 1'b0;
                pos_next      = '0;
            end
        end
        else if (accept)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + ssr_pkg::count_t'(1);
            end
            if (record.last_record)
            begin
                emit_next = 1'b1;
                pos_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            emit_reg         <= 1'b0;
            pos_reg          <= '0;
            rank_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            overflow_reg     <= overflow_next;
            emit_reg         <= emit_next;
            pos_reg          <= pos_next;
            rank_reg         <= rank_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_score_reg <= prev_score_next;
        result_reg     <= result_next;
    end

    assign busy         = emit_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

>>> rtl/ssr_checker.sv
// port-level checker for score_sort_rank and its bind
`default_nettype none

`include "assert_macros.svh"

module ssr_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire ssr_pkg::in_t  record,
    input wire logic          busy,
    input wire logic          result_valid,
    input wire ssr_pkg::out_t result
);

    `SSR_ASSERT_NEXT(a_close_goes_busy, clk, rst_n, start && !busy && record.last_record, busy, "closing transaction did not raise busy")

    `SSR_ASSERT_SAME(a_last_frees_block, clk, rst_n, result_valid && result.last_result, !busy, "busy still high on final result")

    `SSR_ASSERT_NEXT(a_results_contiguous, clk, rst_n, result_valid && !result.last_result, result_valid, "gap inside a ranked run")

    `SSR_ASSERT_NEXT(a_sorted_order, clk, rst_n, result_valid && !result.last_result, (result.score_res <= $past(result.score_res)) && (result.rank >= $past(result.rank)), "ranked run out of order")

endmodule

bind score_sort_rank ssr_checker u_ssr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .record       (record),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

>>> tb/tb_score_sort_rank.sv
// self-checking testbench for score_sort_rank: directed table, random sets, ranked-order checks
module tb_score_sort_rank;
    timeunit 1ns;
    timeprecision 1ps;

    import ssr_pkg::*;

    localparam int ITEM_TARGET = 470;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int N_DIRECTED  = 19;

    // one row of the directed table; want is only meaningful where typed is set
    typedef struct packed {
        in_t  rec;
        logic typed;
        out_t want;
    } row_t;

    row_t directed_rows [N_DIRECTED] = '{
        '{'{20'hFFFFF, 16'hFFFF, 1'b1}, 1'b1, '{20'hFFFFF, 16'hFFFF, 7'd1, 1'b1, 1'b0}},
        '{'{20'h00000, 16'h0000, 1'b1}, 1'b1, '{20'h00000, 16'h0000, 7'd1, 1'b1, 1'b0}},
        // interleaved ties, ranks skip after each tie group
        '{'{20'h12345, 16'd500, 1'b0}, 1'b0, '0},
        '{'{20'h23456, 16'd700, 1'b0}, 1'b0, '0},
        '{'{20'h34567, 16'd500, 1'b0}, 1'b0, '0},
        '{'{20'h45678, 16'd700, 1'b0}, 1'b0, '0},
        '{'{20'h56789, 16'd100, 1'b1}, 1'b0, '0},
        // all equal scores share rank one
        '{'{20'hAAAAA, 16'd1234, 1'b0}, 1'b0, '0},
        '{'{20'h55555, 16'd1234, 1'b0}, 1'b0, '0},
        '{'{20'h0F0F0, 16'd1234, 1'b1}, 1'b0, '0},
        // ascending arrival comes out reversed
        '{'{20'h00001, 16'd1, 1'b0}, 1'b0, '0},
        '{'{20'h00002, 16'd2, 1'b0}, 1'b0, '0},
        '{'{20'h00003, 16'd3, 1'b0}, 1'b0, '0},
        '{'{20'h00004, 16'd4, 1'b1}, 1'b0, '0},
        '{'{20'hFFFFE, 16'hFFFF, 1'b0}, 1'b0, '0},
        '{'{20'h00010, 16'h0000, 1'b0}, 1'b0, '0},
        '{'{20'h80000, 16'hFFFF, 1'b1}, 1'b0, '0},
        '{'{20'h7FFFF, 16'h0000, 1'b0}, 1'b0, '0},
        '{'{20'h00020, 16'h0000, 1'b1}, 1'b0, '0}
    };

    logic clk;
    logic rst_n;
    logic start;
    in_t  record;
    logic busy;
    logic result_valid;
    out_t result;

    // predictor state: records of the open set in ranked order
    rec_t sorted_records [$];
    logic set_overflow;
    out_t ranked_expect [$];

    int mismatches;
    int cycle_count;
    int sender_idle_pct;

    score_sort_rank i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .record       (record),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // place one record behind every stored record with an equal or higher score, or flag the
    // set when it is full; on the closing record, rank the set and queue the results if asked
    task automatic load_record(input in_t r, input bit keep_results);
        int   pos;
        rank_t rank_now;
        out_t res;
        if (sorted_records.size() >= MAX_RECORDS)
            set_overflow = 1'b1;
        else
        begin
            pos = 0;
            while (pos < sorted_records.size() && sorted_records[pos].score >= r.score)
                pos++;
            sorted_records.insert(pos, rec_t'{r.student_id, r.score});
        end
        if (r.last_record)
        begin
            rank_now = rank_t'(1);
            foreach (sorted_records[i])
            begin
                if (i > 0 && sorted_records[i].score != sorted_records[i-1].score)
                    rank_now = rank_t'(i + 1);
                res.student_id_res = sorted_records[i].id;
                res.score_res      = sorted_records[i].score;
                res.rank           = rank_now;
                res.last_result    = (i == sorted_records.size() - 1);
                res.dropped_any    = set_overflow;
                if (keep_results)
                    ranked_expect.push_back(res);
            end
            sorted_records.delete();
            set_overflow = 1'b0;
        end
    endtask

    // start stays high after a transaction so back-to-back records need no toggle
    task automatic send_record(input in_t r, input bit typed, input out_t want);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start  <= 1'b0;
            record <= '{id_t'($urandom), score_t'($urandom), 1'($urandom)};
            @(posedge clk);
        end
        start  <= 1'b1;
        record <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        load_record(r, !typed);
        if (typed)
            ranked_expect.push_back(want);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (ranked_expect.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin : check_results
        out_t want;
        if (rst_n && result_valid)
        begin
            if (ranked_expect.size() == 0)
                note_mismatch($sformatf("unexpected result id=%h score=%h rank=%0d",
                                        result.student_id_res, result.score_res,
                                        result.rank));
            else
            begin
                want = ranked_expect.pop_front();
                if (result.student_id_res !== want.student_id_res ||
                    result.score_res !== want.score_res ||
                    result.rank !== want.rank ||
                    result.last_result !== want.last_result ||
                    result.dropped_any !== want.dropped_any)
                    note_mismatch($sformatf(
                        "mismatch: exp id=%h sc=%h rk=%0d last=%b drop=%b, got id=%h sc=%h rk=%0d last=%b drop=%b",
                        want.student_id_res, want.score_res, want.rank,
                        want.last_result, want.dropped_any,
                        result.student_id_res, result.score_res, result.rank,
                        result.last_result, result.dropped_any));
            end
        end
    end

    initial
    begin : stimulus
        int     items_sent;
        int     set_no;
        int     set_len;
        score_t sc;
        score_t prev_score;
        in_t    r;

        mismatches      = 0;
        cycle_count     = 0;
        set_overflow    = 1'b0;
        sender_idle_pct = 0;
        items_sent      = 0;
        prev_score      = '0;
        rst_n  <= 1'b0;
        start  <= 1'b0;
        record <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_record(directed_rows[i].rec, directed_rows[i].typed, directed_rows[i].want);
            items_sent++;
        end

        set_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (set_no)
                4:       set_len = MAX_RECORDS;      // store exactly full
                9:       set_len = MAX_RECORDS + 2;  // overflow, closing record dropped too
                default: set_len = $urandom_range(1, 10);
            endcase
            // hold the sender until the previous set has fully drained
            if (set_no == 6)
                drain_results();
            for (int k = 0; k < set_len; k++)
            begin
                case ((items_sent / 50) % 3)
                    0:       sender_idle_pct = 0;
                    1:       sender_idle_pct = 58;
                    default: sender_idle_pct = 10;
                endcase
                case ($urandom_range(3))
                    0:       sc = score_t'($urandom);
                    1:       sc = score_t'($urandom_range(7) * 1250);
                    2:       sc = ($urandom_range(1) == 1) ? '1 : '0;
                    default: sc = prev_score;
                endcase
                prev_score = sc;
                r.student_id  = id_t'($urandom);
                r.score       = sc;
                r.last_record = (k == set_len - 1);
                send_record(r, 1'b0, '0);
                items_sent++;
            end
            set_no++;
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && ranked_expect.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ssr_pkg.sv
rtl/ssr_cell.sv
rtl/ssr_chain.sv
rtl/score_sort_rank.sv
rtl/ssr_checker.sv
tb/tb_score_sort_rank.sv
